FILE: rtl/pws_pkg.sv
// Shared types and constants for the power sample smoothing filter.
// Used by every module of the block; depends on nothing else.
package pws_pkg;

    // Field widths
    localparam int RawW     = 16;
    localparam int MagW     = 15;
    localparam int ScaleW   = 11;
    localparam int ShiftW   = 4;
    localparam int TimeW    = 32;
    localparam int PowerW   = 15;
    localparam int AvgW     = 23;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    // Fixed-point constants
    localparam int unsigned Q8Bits = 8;
    localparam logic [AvgW:0] Q8Half = (AvgW+1)'(128);
    localparam logic [PowerW-1:0] OutMax = {PowerW{1'b1}};

    // Register reset values
    localparam logic [ScaleW-1:0]  ScaleReset   = ScaleW'(256);
    localparam logic               SmoothReset  = 1'b1;
    localparam logic [ShiftW-1:0]  ShiftReset   = ShiftW'(3);
    localparam logic [TimeW-1:0]   TimeoutReset = TimeW'(3000);

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCALE         = 2'd0,
        CFG_SMOOTH_EN     = 2'd1,
        CFG_SMOOTH_SHIFT  = 2'd2,
        CFG_STALE_TIMEOUT = 2'd3
    } cfg_index_t;

    // Request kinds
    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_TIME   = 1'b1
    } req_t;

    // Current configuration
    typedef struct packed {
        logic [ScaleW-1:0] scale_q8;
        logic              smooth_enable;
        logic [ShiftW-1:0] smooth_shift;
        logic [TimeW-1:0]  stale_timeout_ms;
    } cfg_t;

    // Item after gain and saturation
    typedef struct packed {
        req_t              req;
        logic [PowerW-1:0] scaled;
        logic [TimeW-1:0]  now_ms;
    } item_t;

endpackage

FILE: rtl/pws_scale.sv
// Input register and gain stage: clamp, multiply by the Q8 gain, saturate.
// Depends on pws_pkg.
module pws_scale
    import pws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic signed [RawW-1:0]   raw_watts,
    input  logic [TimeW-1:0]         now_ms,
    input  logic [ScaleW-1:0]        scale_q8,
    output logic                     item_valid,
    output item_t                    item,
    input  logic                     item_take
);

    logic              s1_valid_reg;
    logic              s1_req_reg;
    logic [RawW-1:0]   s1_raw_reg;
    logic [TimeW-1:0]  s1_now_reg;
    logic              s2_valid_reg;
    item_t             s2_item_reg;
    item_t             s2_item_next;

    logic              s1_move;
    logic              s2_move;
    logic [MagW-1:0]   mag;
    logic [MagW+ScaleW-1:0] prod;
    logic [MagW+ScaleW-Q8Bits-1:0] prod_q0;

    // Advance a stage when it is empty or its contents move on
    assign s2_move  = !s2_valid_reg || item_take;
    assign s1_move  = !s1_valid_reg || s2_move;
    assign in_stall = !s1_move;

    // Clamp negatives at zero, scale and saturate
    always_comb
    begin
        mag     = s1_raw_reg[RawW-1] ? '0 : s1_raw_reg[MagW-1:0];
        prod    = (MagW+ScaleW)'(mag) * (MagW+ScaleW)'(scale_q8);
        prod_q0 = prod[MagW+ScaleW-1:Q8Bits];
        s2_item_next.req    = req_t'(s1_req_reg);
        s2_item_next.now_ms = s1_now_reg;
        if (prod_q0 > (MagW+ScaleW-Q8Bits)'(OutMax))
        begin
            s2_item_next.scaled = OutMax;
        end
        else
        begin
            s2_item_next.scaled = prod_q0[PowerW-1:0];
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_move)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Load payloads on each transfer
    always_ff @(posedge clk)
    begin
        if (s1_move && in_valid)
        begin
            s1_req_reg <= req_type;
            s1_raw_reg <= raw_watts;
            s1_now_reg <= now_ms;
        end
        if (s2_move && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

FILE: rtl/pws_avg.sv
// Moving average state, staleness check and result register.
// Depends on pws_pkg.
module pws_avg
    import pws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PowerW-1:0]  power_watts,
    output logic               stale
);

    logic [AvgW-1:0]    avg_reg;
    logic [AvgW-1:0]    avg_next;
    logic               seeded_reg;
    logic               seeded_next;
    logic [TimeW-1:0]   stamp_reg;
    logic [TimeW-1:0]   stamp_next;
    logic [PowerW-1:0]  last_out_reg;
    logic [PowerW-1:0]  last_out_next;
    logic               stale_reg;
    logic               stale_next;
    logic               out_valid_reg;

    logic               commit;
    logic [AvgW-1:0]    target;
    logic signed [AvgW:0] diff;
    logic signed [AvgW:0] bias;
    logic signed [AvgW:0] step;
    logic [AvgW:0]      sum;
    logic [AvgW:0]      rounded;
    logic [TimeW-1:0]   age;

    // Take an item whenever the result register is free or being drained
    assign item_take = !out_valid_reg || !out_stall;
    assign commit    = item_valid && item_take;

    // Average step: move by (target - avg) / 2^shift, truncating toward zero
    always_comb
    begin
        target  = {item.scaled, Q8Bits'(0)};
        diff    = $signed({1'b0, target}) - $signed({1'b0, avg_reg});
        bias    = diff[AvgW] ? $signed(((AvgW+1)'(1) << cfg.smooth_shift) - (AvgW+1)'(1))
                             : '0;
        step    = (diff + bias) >>> cfg.smooth_shift;
        sum     = {1'b0, avg_reg} + $unsigned(step);
        rounded = (sum + Q8Half) >> Q8Bits;
    end

    // Next state for one committed item
    always_comb
    begin
        avg_next      = avg_reg;
        seeded_next   = seeded_reg;
        stamp_next    = stamp_reg;
        last_out_next = last_out_reg;
        if (item.req == REQ_SAMPLE)
        begin
            stamp_next = item.now_ms;
            if (!cfg.smooth_enable || item.scaled == '0)
            begin
                avg_next      = target;
                seeded_next   = (item.scaled != '0);
                last_out_next = item.scaled;
            end
            else if (!seeded_reg)
            begin
                avg_next      = target;
                seeded_next   = 1'b1;
                last_out_next = item.scaled;
            end
            else
            begin
                avg_next = sum[AvgW-1:0];
                if (rounded > (AvgW+1)'(OutMax))
                begin
                    last_out_next = OutMax;
                end
                else
                begin
                    last_out_next = rounded[PowerW-1:0];
                end
            end
        end
    end

    // Stale only on a time check: a sample stamps the current time
    always_comb
    begin
        age        = item.now_ms - stamp_reg;
        stale_next = (item.req == REQ_TIME) && (stamp_reg != '0)
                     && (age > cfg.stale_timeout_ms);
    end

    // Update state and the result register on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= '0;
            seeded_reg    <= 1'b0;
            stamp_reg     <= '0;
            last_out_reg  <= '0;
            stale_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                out_valid_reg <= item_valid;
            end
            if (commit)
            begin
                avg_reg      <= avg_next;
                seeded_reg   <= seeded_next;
                stamp_reg    <= stamp_next;
                last_out_reg <= last_out_next;
                stale_reg    <= stale_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign power_watts = last_out_reg;
    assign stale       = stale_reg;

endmodule

FILE: rtl/power_sample_ema_filter.sv
// Top level of the power sample smoothing filter: configuration registers,
// gain stage and averaging stage. Depends on pws_pkg, pws_scale, pws_avg.
//
// Input channel: in_valid / in_stall with req_type, raw_watts, now_ms. A
// power sample (req_type 0) updates the smoothed power; a time check
// (req_type 1) only re-evaluates staleness. Each transfer yields exactly one
// result on the output channel: out_valid / out_stall with power_watts and
// stale.
// A result passes through the input register, the gain multiply register
// and the result register.
// Throughput: one item per cycle unless the output stalls; the averaging
// state is updated in the same cycle that a result is loaded, so consecutive
// items see each other's state. A stalled result is held; up to two more
// items are held behind it, after which in_stall rises.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 gain,
// 1 smoothing enable, 2 shift, 3 timeout); write only while the block is idle.
// Reset clears the average, the sample stamp and the output, loads default
// configuration and empties the pipeline. There is no clearing pass.
module power_sample_ema_filter
    import pws_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic signed [RawW-1:0]  raw_watts,
    input  logic [TimeW-1:0]        now_ms,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PowerW-1:0]       power_watts,
    output logic                    stale,
    input  logic                    cfg_we,
    input  logic [CfgIdxW-1:0]      cfg_index,
    input  logic [CfgDataW-1:0]     cfg_data
);

    cfg_t   cfg_reg;
    logic   item_valid;
    item_t  item;
    logic   item_take;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_q8         <= ScaleReset;
            cfg_reg.smooth_enable    <= SmoothReset;
            cfg_reg.smooth_shift     <= ShiftReset;
            cfg_reg.stale_timeout_ms <= TimeoutReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCALE:         cfg_reg.scale_q8         <= cfg_data[ScaleW-1:0];
                CFG_SMOOTH_EN:     cfg_reg.smooth_enable    <= cfg_data[0];
                CFG_SMOOTH_SHIFT:  cfg_reg.smooth_shift     <= cfg_data[ShiftW-1:0];
                CFG_STALE_TIMEOUT: cfg_reg.stale_timeout_ms <= cfg_data[TimeW-1:0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Gain stage
    pws_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .raw_watts  (raw_watts),
        .now_ms     (now_ms),
        .scale_q8   (cfg_reg.scale_q8),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Averaging stage and result register
    pws_avg u_avg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_watts (power_watts),
        .stale       (stale)
    );

endmodule

FILE: rtl/pws_checker.sv
// Port-level checks for the power sample smoothing filter, bound to the top.
// Depends on pws_pkg and power_sample_ema_filter.
module pws_checker
    import pws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [PowerW-1:0]  power_watts,
    input  logic               stale
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_watts) && $stable(stale))
        else $error("stalled result changed");

    // Input is only pushed back when the output side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // A result leaves only by a transfer
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without transfer");

endmodule

bind power_sample_ema_filter pws_checker u_pws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .power_watts (power_watts),
    .stale       (stale)
);
